// ===== rtl/core/cpes_pkg.sv =====
package cpes_pkg;

    // constant pool tag codes
    localparam logic [7:0] TAG_UTF8         = 8'd1;
    localparam logic [7:0] TAG_INTEGER      = 8'd3;
    localparam logic [7:0] TAG_FLOAT        = 8'd4;
    localparam logic [7:0] TAG_LONG         = 8'd5;
    localparam logic [7:0] TAG_DOUBLE       = 8'd6;
    localparam logic [7:0] TAG_CLASS        = 8'd7;
    localparam logic [7:0] TAG_STRING       = 8'd8;
    localparam logic [7:0] TAG_FIELDREF     = 8'd9;
    localparam logic [7:0] TAG_METHODREF    = 8'd10;
    localparam logic [7:0] TAG_IFACE_METHOD = 8'd11;
    localparam logic [7:0] TAG_NAME_TYPE    = 8'd12;

    // input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_item;

    // result transfer payload
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [15:0] entry_index;
        logic [7:0]  entry_tag;
        logic [16:0] entry_offset;
        logic        entry_end;
        logic        pool_end;
        logic        bad_tag;
    } t_out_item;

    // tag decode result
    typedef struct packed {
        logic       known;
        logic [3:0] body_len;
    } t_tag_info;

    // body length of a fixed-size tag; utf8 gets its two length bytes only
    function automatic t_tag_info tag_decode(input logic [7:0] tag);
        t_tag_info info;
        info.known    = 1'b1;
        info.body_len = 4'd0;
        case (tag)
            TAG_CLASS, TAG_STRING, TAG_UTF8: begin
                info.body_len = 4'd2;
            end
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFACE_METHOD, TAG_NAME_TYPE: begin
                info.body_len = 4'd4;
            end
            TAG_LONG, TAG_DOUBLE: begin
                info.body_len = 4'd8;
            end
            default: begin
                info.known = 1'b0;
            end
        endcase
        return info;
    endfunction

endpackage

// ===== rtl/core/constant_pool_entry_splitter.sv =====
// channel   direction  handshake                       payload
// input     in         i_in_valid / o_in_stall         i_in  (t_in_item)
// result    out        o_out_valid / i_out_stall       o_out (t_out_item)
// config    in         i_cfg_wr_en                     i_cfg_wr_data (pool count)
//
// one byte per cycle unless a held result stalls the input
// the rate is set by the single parse step between input and result registers
// bytes that yield no result (idle, halted) are consumed without an output
// reset is synchronous active low and clears parse state and both valid flags
// a stalled result holds; the input register keeps filling until it is full
module constant_pool_entry_splitter
    import cpes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_pool_count;
    logic        s_advance;
    logic        s_in_take;
    logic        s_has_result;
    t_out_item   s_result;

    // pipeline control
    assign s_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_advance;
    assign s_in_take  = i_in_valid && !o_in_stall;

    // pool count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_count <= 16'd1;
        end else if (i_cfg_wr_en) begin
            r_pool_count <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_take) begin
            r_in_valid <= 1'b1;
        end else if (s_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in <= i_in;
        end
    end

    cpes_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s_advance),
        .i_item       (r_in),
        .i_pool_count (r_pool_count),
        .o_has_result (s_has_result),
        .o_result     (s_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= s_has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_has_result) begin
            r_out <= s_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/cpes_parser.sv =====
module cpes_parser
    import cpes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    input  logic [15:0] i_pool_count,
    output logic        o_has_result,
    output t_out_item   o_result
);

    logic        r_active, n_active;
    logic [15:0] r_index,  n_index;
    logic [7:0]  r_tag,    n_tag;
    logic [16:0] r_pos,    n_pos;
    logic [16:0] r_blen,   n_blen;

    // parse step for one byte
    always_comb begin
        t_tag_info   info;
        logic        ok;
        logic        at_end;
        logic        two_slot;
        logic [16:0] next_idx;
        logic [15:0] idx;
        logic [16:0] pos;

        n_active = r_active;
        n_index  = r_index;
        n_tag    = r_tag;
        n_pos    = r_pos;
        n_blen   = r_blen;
        info     = tag_decode(i_item.data_byte);
        ok       = 1'b1;
        at_end   = 1'b0;
        two_slot = 1'b0;
        next_idx = '0;
        o_has_result = 1'b0;
        o_result     = '0;

        // start of a new pool drops any partial entry
        if (i_item.first) begin
            n_index  = 16'd1;
            n_tag    = 8'd0;
            n_pos    = '0;
            n_blen   = '0;
            n_active = (i_pool_count > 16'd1);
        end
        idx = n_index;
        pos = n_pos;

        if (n_active) begin
            o_has_result = 1'b1;
            if (pos == 17'd0) begin
                n_tag = i_item.data_byte;
                if (!info.known) begin
                    ok = 1'b0;
                end else begin
                    n_blen = {13'd0, info.body_len};
                end
            end else if (n_tag == TAG_UTF8 && pos == 17'd1) begin
                n_blen = 17'd2 + {1'b0, i_item.data_byte, 8'h00};
            end else if (n_tag == TAG_UTF8 && pos == 17'd2) begin
                n_blen = n_blen + {9'd0, i_item.data_byte};
            end

            if (!ok) begin
                // unknown tag: report once, then idle until next start
                n_active              = 1'b0;
                o_result.byte_out     = i_item.data_byte;
                o_result.entry_index  = idx;
                o_result.entry_tag    = i_item.data_byte;
                o_result.entry_offset = '0;
                o_result.bad_tag      = 1'b1;
            end else begin
                at_end   = (pos == n_blen);
                two_slot = (n_tag == TAG_LONG) || (n_tag == TAG_DOUBLE);
                next_idx = {1'b0, idx} + (two_slot ? 17'd2 : 17'd1);
                o_result.byte_out     = i_item.data_byte;
                o_result.entry_index  = idx;
                o_result.entry_tag    = n_tag;
                o_result.entry_offset = pos;
                o_result.entry_end    = at_end;
                if (at_end) begin
                    n_pos = '0;
                    if (next_idx >= {1'b0, i_pool_count}) begin
                        o_result.pool_end = 1'b1;
                        n_active          = 1'b0;
                    end else begin
                        n_index = next_idx[15:0];
                    end
                end else begin
                    n_pos = pos + 17'd1;
                end
            end
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_index  <= 16'd1;
            r_tag    <= 8'd0;
            r_pos    <= '0;
            r_blen   <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_index  <= n_index;
            r_tag    <= n_tag;
            r_pos    <= n_pos;
            r_blen   <= n_blen;
        end
    end

endmodule

// ===== rtl/core/cpes_checker.sv =====
module cpes_checker
    import cpes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // the input only backs up behind a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // an error result sits on the tag and ends nothing
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.bad_tag |->
            o_out.entry_offset == 17'd0 && !o_out.entry_end && !o_out.pool_end
            && o_out.entry_tag == o_out.byte_out)
        else $error("malformed bad tag result");

    // pool end only on the last byte of an entry
    a_pool_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.pool_end |-> o_out.entry_end)
        else $error("pool end without entry end");

    // entry indexes start at one and the tag byte carries its own value
    a_tag_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.entry_index != 16'd0
            && (o_out.entry_offset != 17'd0 || o_out.entry_tag == o_out.byte_out))
        else $error("bad index or tag byte");

endmodule

bind constant_pool_entry_splitter cpes_checker u_cpes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out         (o_out)
);
